// File: rtl/nst_pkg.sv
`timescale 1ns / 1ps
package nst_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned QueueDepth   = 16;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned CountW = 16;
  localparam int unsigned OpensW = 8;
  localparam int unsigned PidW   = 8;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_WAIT  = 2'd1,
    OP_POST  = 2'd2,
    OP_CLOSE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_QUEUE_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_QSCAN,
    S_SHIFT,
    S_OUT
  } state_e;

endpackage

// File: rtl/nst_queue_mem.sv
`timescale 1ns / 1ps
module nst_queue_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [nst_pkg::PidW-1:0]  wdata_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [nst_pkg::PidW-1:0]  rdata_o
);
  import nst_pkg::*;

  logic [PidW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/named_semaphore_table.sv
`timescale 1ns / 1ps
// Table of named counting semaphores with a FIFO wait queue per entry. Keys,
// counts, open counts and fill levels sit in one entry memory, the blocked
// process ids in a second queue memory; both are read synchronously, with
// registered read data. One word is handled at a time: the table is scanned
// one entry per cycle for the key and for a free slot. A wait that has to
// queue its caller first scans its queue for duplicates, and a post that
// wakes a process shifts the queue forward.
module named_semaphore_table #(
  parameter int unsigned TABLE_ENTRIES = nst_pkg::TableEntries,
  parameter int unsigned QUEUE_DEPTH   = nst_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [nst_pkg::KeyW-1:0]    name_key_i,
  input  logic [nst_pkg::CountW-1:0]  initial_value_i,
  input  logic [nst_pkg::PidW-1:0]    caller_pid_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic                        caller_blocked_o,
  output logic                        woken_valid_o,
  output logic [nst_pkg::PidW-1:0]    woken_pid_o
);
  import nst_pkg::*;

  localparam int unsigned EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned AW = EW + QW;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
    logic [OpensW-1:0] opens;
    logic [FW-1:0]     fill;
  } entry_t;

  // Entry memory with used bits in flip-flops.
  entry_t                 emem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] used_q, used_d;
  logic                   ewe;
  logic [EW-1:0]          eaddr_w, eaddr_r;
  entry_t                 ewdata, erdata_q;

  always_ff @(posedge clk_i) begin
    if (ewe) begin
      emem[eaddr_w] <= ewdata;
    end
    erdata_q <= emem[eaddr_r];
  end

  // Queue memory.
  logic            qwe;
  logic [AW-1:0]   qwaddr, qraddr;
  logic [PidW-1:0] qwdata, qrdata;

  nst_queue_mem #(
    .Depth(2 ** AW),
    .AddrW(AW)
  ) u_qmem (
    .clk_i  (clk_i),
    .we_i   (qwe),
    .waddr_i(qwaddr),
    .wdata_i(qwdata),
    .raddr_i(qraddr),
    .rdata_o(qrdata)
  );

  state_e state_q, state_d;
  logic [1:0]        op_q;
  logic [KeyW-1:0]   key_q;
  logic [CountW-1:0] init_q;
  logic [PidW-1:0]   pid_q;
  logic [SW-1:0]     scan_q, scan_d;
  logic              rd_pend_q, rd_pend_d;
  logic              hit_q, hit_d, free_ok_q, free_ok_d;
  logic [EW-1:0]     hit_q_idx, hit_d_idx, free_q_idx, free_d_idx;
  entry_t            ent_q, ent_d;
  logic [FW-1:0]     qi_q, qi_d;
  logic              present_q, present_d;
  logic [1:0]        st_q, st_d;
  logic              blk_q, blk_d, wv_q, wv_d;
  logic [PidW-1:0]   wp_q, wp_d;
  logic [EW-1:0]     scan_idx, last_idx;

  assign scan_idx = scan_q[EW-1:0];
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o = st_q;
  assign caller_blocked_o = blk_q;
  assign woken_valid_o = wv_q;
  assign woken_pid_o = wp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q <= opcode_i;
      key_q <= name_key_i;
      init_q <= initial_value_i;
      pid_q <= caller_pid_i;
    end
    scan_q <= scan_d;
    hit_q <= hit_d;
    free_ok_q <= free_ok_d;
    hit_q_idx <= hit_d_idx;
    free_q_idx <= free_d_idx;
    ent_q <= ent_d;
    qi_q <= qi_d;
    present_q <= present_d;
    st_q <= st_d;
    blk_q <= blk_d;
    wv_q <= wv_d;
    wp_q <= wp_d;
  end

  always_comb begin
    state_d = state_q;
    used_d = used_q;
    scan_d = scan_q;
    rd_pend_d = 1'b0;
    hit_d = hit_q;
    free_ok_d = free_ok_q;
    hit_d_idx = hit_q_idx;
    free_d_idx = free_q_idx;
    ent_d = ent_q;
    qi_d = qi_q;
    present_d = present_q;
    st_d = st_q;
    blk_d = blk_q;
    wv_d = wv_q;
    wp_d = wp_q;
    ewe = 1'b0;
    eaddr_w = hit_q_idx;
    eaddr_r = scan_idx;
    ewdata = ent_q;
    qwe = 1'b0;
    qwaddr = {hit_q_idx, qi_q[QW-1:0]};
    qwdata = pid_q;
    qraddr = {hit_q_idx, qi_q[QW-1:0]};
    last_idx = scan_idx - EW'(1);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCAN;
          scan_d = '0;
          hit_d = 1'b0;
          free_ok_d = 1'b0;
          st_d = ST_OK;
          blk_d = 1'b0;
          wv_d = 1'b0;
          wp_d = '0;
        end
      end
      S_SCAN: begin
        // Issue read of entry scan_q, evaluate the entry read last cycle.
        if (rd_pend_q) begin
          if (used_q[last_idx] && !hit_q && erdata_q.key == key_q) begin
            hit_d = 1'b1;
            hit_d_idx = last_idx;
            ent_d = erdata_q;
          end
        end
        if (scan_q < SW'(TABLE_ENTRIES)) begin
          if (!used_q[scan_idx] && !free_ok_q) begin
            free_ok_d = 1'b1;
            free_d_idx = scan_idx;
          end
          rd_pend_d = 1'b1;
          scan_d = scan_q + SW'(1);
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_OUT;
        qi_d = '0;
        present_d = 1'b0;
        case (op_q)
          OP_OPEN: begin
            if (hit_q) begin
              ewe = 1'b1;
              ewdata = ent_q;
              if (ent_q.opens != '1) ewdata.opens = ent_q.opens + OpensW'(1);
            end else if (!free_ok_q) begin
              st_d = ST_TABLE_FULL;
            end else begin
              ewe = 1'b1;
              eaddr_w = free_q_idx;
              ewdata.key = key_q;
              ewdata.count = init_q;
              ewdata.opens = OpensW'(1);
              ewdata.fill = '0;
              used_d[free_q_idx] = 1'b1;
            end
          end
          OP_WAIT: begin
            if (!hit_q) begin
              st_d = ST_NOT_FOUND;
            end else if (ent_q.count != '0) begin
              ewe = 1'b1;
              ewdata.count = ent_q.count - CountW'(1);
            end else begin
              state_d = S_QSCAN;
              rd_pend_d = 1'b0;
            end
          end
          OP_POST: begin
            if (!hit_q) begin
              st_d = ST_NOT_FOUND;
            end else if (ent_q.fill != '0) begin
              state_d = S_SHIFT;
              wv_d = 1'b1;
            end else if (ent_q.count != '1) begin
              ewe = 1'b1;
              ewdata.count = ent_q.count + CountW'(1);
            end
          end
          default: begin
            if (!hit_q) begin
              st_d = ST_NOT_FOUND;
            end else begin
              ewe = 1'b1;
              if (ent_q.opens > OpensW'(1)) begin
                ewdata.opens = ent_q.opens - OpensW'(1);
              end else begin
                ewdata.opens = '0;
                ewdata.fill = '0;
                used_d[hit_q_idx] = 1'b0;
              end
            end
          end
        endcase
      end
      S_QSCAN: begin
        // qi_q is the next slot to read; compare the slot read last cycle.
        if (rd_pend_q && qrdata == pid_q) present_d = 1'b1;
        if (qi_q < ent_q.fill) begin
          rd_pend_d = 1'b1;
          qi_d = qi_q + FW'(1);
        end else begin
          state_d = S_OUT;
          if (present_d) begin
            blk_d = 1'b1;
          end else if (ent_q.fill >= FW'(QUEUE_DEPTH)) begin
            st_d = ST_QUEUE_FULL;
          end else begin
            qwe = 1'b1;
            qwaddr = {hit_q_idx, ent_q.fill[QW-1:0]};
            ewe = 1'b1;
            ewdata.fill = ent_q.fill + FW'(1);
            blk_d = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        // Read slot qi_q; write data read last cycle into slot qi_q - 2.
        if (rd_pend_q) begin
          if (qi_q == FW'(1)) begin
            wp_d = qrdata;
          end else begin
            qwe = 1'b1;
            qwaddr = {hit_q_idx, QW'(qi_q - FW'(2))};
            qwdata = qrdata;
          end
        end
        if (qi_q < ent_q.fill) begin
          rd_pend_d = 1'b1;
          qi_d = qi_q + FW'(1);
        end else begin
          state_d = S_OUT;
          ewe = 1'b1;
          ewdata.fill = ent_q.fill - FW'(1);
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: rtl/nst_checker.sv
`timescale 1ns / 1ps
module nst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic       caller_blocked_o,
  input logic       woken_valid_o,
  input logic [7:0] woken_pid_o
);
  import nst_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (caller_blocked_o || woken_valid_o) |-> status_o == ST_OK)
    else $error("flags set on an error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !woken_valid_o |-> woken_pid_o == '0)
    else $error("woken pid without wake");

endmodule

bind named_semaphore_table nst_checker u_nst_checker (.*);
